>>> hdl/whole_word_keyword_line_match_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the whole-word keyword line matcher
// Shared macros for the concurrent checks in the matcher's modules.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_KEYWORD_LINE_MATCH_ASSERT_SVH
`define WHOLE_WORD_KEYWORD_LINE_MATCH_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define WWKLM_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWKLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/wwklm_pkg.sv
// ----------------------------------------------------------------------------
// Whole-word keyword line matcher package
// Types, register indexes and byte classification shared by the matcher.
// ----------------------------------------------------------------------------
package wwklm_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [LEN_W-1:0]     key_len_t;

    localparam cfg_index_t REG_KEYWORD_LOW    = 2'd0;
    localparam cfg_index_t REG_KEYWORD_HIGH   = 2'd1;
    localparam cfg_index_t REG_KEYWORD_LENGTH = 2'd2;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam key_len_t   POS_LIMIT  = 5'd31;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        key_len_t    length;
    } keyword_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } result_push_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

>>> hdl/wwklm_cfg.sv
// ----------------------------------------------------------------------------
// Keyword register bank
// Holds the keyword bytes and length written through the configuration port.
// ----------------------------------------------------------------------------
module wwklm_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  wwklm_pkg::cfg_index_t cfg_index,
    input  logic [63:0]          cfg_data,
    output wwklm_pkg::keyword_t  keyword
);
    import wwklm_pkg::*;

    keyword_t kw_reg;
    keyword_t kw_next;

    assign cfg_ready = 1'b1;
    assign keyword   = kw_reg;

    always_comb begin
        kw_next = kw_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_KEYWORD_LOW:    kw_next.low    = cfg_data;
                REG_KEYWORD_HIGH:   kw_next.high   = cfg_data;
                REG_KEYWORD_LENGTH: kw_next.length = cfg_data[LEN_W-1:0];
                default:            kw_next = kw_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg <= '0;
        end else begin
            kw_reg <= kw_next;
        end
    end

endmodule

>>> hdl/wwklm_core.sv
// ----------------------------------------------------------------------------
// Word matcher core
// Registers each accepted byte, then updates the per-word compare state and
// emits the line verdict when an end-of-line item reaches the stage.
// ----------------------------------------------------------------------------
`include "whole_word_keyword_line_match_assert.svh"

module wwklm_core #(
    parameter int KEY_MAX = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_accept,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  wwklm_pkg::keyword_t     keyword,
    output wwklm_pkg::result_push_t push
);
    import wwklm_pkg::*;

    localparam key_len_t KEY_MAX_LEN = key_len_t'(KEY_MAX);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    key_len_t pos_reg,         pos_next;
    logic     agree_reg,       agree_next;
    logic     eq_reg,          eq_next;
    logic     alnum_seen_reg,  alnum_seen_next;
    logic     word_open_reg,   word_open_next;
    logic     found_reg,       found_next;

    logic [15:0][7:0] key_bytes;
    key_len_t         used_len;
    logic             is_an;
    logic             byte_ok;
    logic             close_hit;

    assign key_bytes = {keyword.high, keyword.low};
    assign used_len  = (keyword.length > KEY_MAX_LEN) ? KEY_MAX_LEN : keyword.length;
    assign is_an     = is_alnum(in_byte_reg);
    assign byte_ok   = (pos_reg < used_len) &&
                       (fold_case(key_bytes[pos_reg[3:0]]) == fold_case(in_byte_reg));
    assign close_hit = word_open_reg &&
                       (alnum_seen_reg ? eq_reg : (used_len == '0));

    always_comb begin
        pos_next        = pos_reg;
        agree_next      = agree_reg;
        eq_next         = eq_reg;
        alnum_seen_next = alnum_seen_reg;
        word_open_next  = word_open_reg;
        found_next      = found_reg;
        push.valid      = 1'b0;
        push.hit        = found_reg || close_hit;
        if (in_valid_reg) begin
            if (in_last_reg || in_byte_reg == SPACE_BYTE) begin
                pos_next        = '0;
                agree_next      = 1'b1;
                eq_next         = 1'b0;
                alnum_seen_next = 1'b0;
                word_open_next  = 1'b0;
                if (in_last_reg) begin
                    push.valid = 1'b1;
                    found_next = 1'b0;
                end else begin
                    found_next = found_reg || close_hit;
                end
            end else begin
                word_open_next  = 1'b1;
                alnum_seen_next = alnum_seen_reg || is_an;
                if (alnum_seen_next) begin
                    agree_next = agree_reg && byte_ok;
                    if (pos_reg < POS_LIMIT) begin
                        pos_next = pos_reg + key_len_t'(1);
                    end
                    if (is_an) begin
                        eq_next = agree_next && (pos_next == used_len);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pos_reg        <= '0;
            agree_reg      <= 1'b1;
            eq_reg         <= 1'b0;
            alnum_seen_reg <= 1'b0;
            word_open_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            in_valid_reg   <= in_accept;
            pos_reg        <= pos_next;
            agree_reg      <= agree_next;
            eq_reg         <= eq_next;
            alnum_seen_reg <= alnum_seen_next;
            word_open_reg  <= word_open_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    `WWKLM_ASSERT_ALWAYS(pos_needs_alnum, aclk, aresetn, (pos_reg == '0) || alnum_seen_reg, "position advanced without an alphanumeric byte")
    `WWKLM_ASSERT_ALWAYS(alnum_needs_word, aclk, aresetn, !alnum_seen_reg || word_open_reg, "alphanumeric byte seen outside an open word")
    `WWKLM_ASSERT_NEXT(line_end_clears, aclk, aresetn, in_valid_reg && in_last_reg, !found_reg && !word_open_reg, "line state not cleared after line end")

endmodule

>>> hdl/wwklm_out.sv
// ----------------------------------------------------------------------------
// Result queue
// Four-word queue of line verdicts that decouples the result channel from
// the input; it reserves room for the one item in flight in the core.
// ----------------------------------------------------------------------------
`include "whole_word_keyword_line_match_assert.svh"

module wwklm_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  wwklm_pkg::result_push_t push,
    output logic                    can_take,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata
);
    import wwklm_pkg::*;

    logic [3:0] q_reg;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;
    logic       pop;

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {7'b0, q_reg[rd_ptr_reg]};
    assign pop      = m_tvalid && m_tready;
    assign can_take = (count_reg < 3'd3);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + 2'(push.valid);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push.valid) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            q_reg[wr_ptr_reg] <= push.hit;
        end
    end

    `WWKLM_ASSERT_ALWAYS(no_overflow, aclk, aresetn, !(push.valid && count_reg == 3'd4), "result pushed into a full queue")
    `WWKLM_ASSERT_NEXT(push_lands, aclk, aresetn, push.valid && !pop, count_reg == $past(count_reg) + 3'd1, "pushed result not counted")

endmodule

>>> hdl/whole_word_keyword_line_match.sv
// ----------------------------------------------------------------------------
// Whole-word keyword line matcher
// Result path: an accepted line-end byte is registered in the core, and its verdict
// is then written into the result queue, which raises m_tvalid; other bytes give no result.
// Throughput: one byte per cycle; input stalls only while three or four verdicts wait.
// Reset: synchronous, active low; clears keyword, word state and result queue.
// ----------------------------------------------------------------------------
module whole_word_keyword_line_match #(
    parameter int KEY_MAX = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] text_byte
    input  logic                  s_tlast,   // end_of_line
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] line_matches, [7:1] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  wwklm_pkg::cfg_index_t cfg_index,
    input  logic [63:0]           cfg_data
);
    import wwklm_pkg::*;

    keyword_t     keyword;
    result_push_t push;
    logic         can_take;

    assign s_tready = can_take;

    wwklm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keyword   (keyword)
    );

    wwklm_core #(
        .KEY_MAX (KEY_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && can_take),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .keyword   (keyword),
        .push      (push)
    );

    wwklm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
